[sv/fern_pkg.sv]
// Shared types, constants and coefficient table for the fern point plotter.
package fern_pkg;

  localparam int IMG_W   = 1024;
  localparam int IMG_H   = 1024;

  localparam int PT_W    = 22;   // Q5.16 point width
  localparam int SCALE_W = 32;   // Q16.16 pixels-per-unit width
  localparam int RAND_W  = 16;
  localparam int PIX_W   = 10;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;
  localparam int MUL_A_W = PT_W + 1;
  localparam int MUL_B_W = SCALE_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int FRAC_W  = 16;
  localparam int SUM_W   = PROD_W - FRAC_W + 1;
  localparam int PIXQ_W  = PROD_W - 32;   // floor(product / 2^32)

  localparam int Q_MAX = 2097151;
  localparam int Q_MIN = -2097152;

  // map select thresholds: 0.01, 0.86, 0.93 of 65536
  localparam logic [RAND_W-1:0] THR_FROND = 16'd656;
  localparam logic [RAND_W-1:0] THR_LEFT  = 16'd56361;
  localparam logic [RAND_W-1:0] THR_RIGHT = 16'd60949;

  localparam logic signed [PT_W-1:0] VIEW_LEFT_RST = -22'sd196608;
  localparam logic signed [PT_W-1:0] VIEW_TOP_RST  = 22'sd688128;
  localparam logic [SCALE_W-1:0]     XPPU_RST      = 32'd11184810;
  localparam logic [SCALE_W-1:0]     YPPU_RST      = 32'd6100806;

  typedef enum logic [1:0] {
    MAP_STEM  = 2'd0,
    MAP_FROND = 2'd1,
    MAP_LEFT  = 2'd2,
    MAP_RIGHT = 2'd3
  } map_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VIEW_LEFT = 4'd0,
    REG_VIEW_TOP  = 4'd1,
    REG_XPPU      = 4'd2,
    REG_YPPU      = 4'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_XA,
    ST_XB,
    ST_YA,
    ST_YB,
    ST_PX,
    ST_PY,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    MUL_XA,
    MUL_XB,
    MUL_YA,
    MUL_YB,
    MUL_COL,
    MUL_ROW
  } mul_sel_e;

  typedef struct packed {
    logic     take_in;   // capture map select from the input word
    logic     mul_en;    // load product register
    mul_sel_e mul_sel;
    logic     acc_load;  // acc <= product
    logic     x_done;    // new x <= sat(floor(acc + product) + offset)
    logic     y_done;
    logic     col_load;
    logic     out_load;  // load result register and commit the point
  } cmd_t;

  typedef struct packed {
    logic signed [16:0] ax;
    logic signed [16:0] bx;
    logic signed [17:0] offx;
    logic signed [16:0] ay;
    logic signed [16:0] by;
    logic signed [17:0] offy;
  } coef_t;

  function automatic coef_t fern_coef(input map_e m);
    coef_t c;
    c = '0;
    unique case (m)
      MAP_STEM: begin
        c.ax = 17'sd0;      c.bx = 17'sd0;      c.offx = 18'sd0;
        c.ay = 17'sd0;      c.by = 17'sd10486;  c.offy = 18'sd0;
      end
      MAP_FROND: begin
        c.ax = 17'sd55706;  c.bx = 17'sd2621;   c.offx = 18'sd0;
        c.ay = -17'sd2621;  c.by = 17'sd55706;  c.offy = 18'sd104858;
      end
      MAP_LEFT: begin
        c.ax = 17'sd13107;  c.bx = -17'sd17039; c.offx = 18'sd0;
        c.ay = 17'sd15073;  c.by = 17'sd14418;  c.offy = 18'sd104858;
      end
      MAP_RIGHT: begin
        c.ax = -17'sd9830;  c.bx = 17'sd18350;  c.offx = 18'sd0;
        c.ay = 17'sd17039;  c.by = 17'sd15729;  c.offy = 18'sd28836;
      end
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

[sv/fern_if.sv]
// Channel interfaces: input word, result word and configuration writes.
interface fern_in_if;
  logic                          valid;
  logic                          ready;
  logic [fern_pkg::RAND_W-1:0]   random_fraction;
  modport source (output valid, output random_fraction, input ready);
  modport sink   (input valid, input random_fraction, output ready);
endinterface

interface fern_out_if;
  logic                             valid;
  logic                             ready;
  logic [fern_pkg::PIX_W-1:0]       pixel_col;
  logic [fern_pkg::PIX_W-1:0]       pixel_row;
  logic                             in_view;
  logic signed [fern_pkg::PT_W-1:0] new_point_x;
  logic signed [fern_pkg::PT_W-1:0] new_point_y;
  logic [1:0]                       map_used;
  modport source (output valid, output pixel_col, output pixel_row, output in_view,
                  output new_point_x, output new_point_y, output map_used, input ready);
  modport sink   (input valid, input pixel_col, input pixel_row, input in_view,
                  input new_point_x, input new_point_y, input map_used, output ready);
endinterface

interface fern_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [fern_pkg::CFG_IDX_W-1:0]   index;
  logic [fern_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/fern_ctrl.sv]
// Sequencer: steps the shared multiplier through the affine and pixel products.
module fern_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output fern_pkg::cmd_t cmd_o
);

  fern_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fern_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.mul_sel = fern_pkg::MUL_XA;
    in_ready_o = 1'b0;
    unique case (state_q)
      fern_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take_in = 1'b1;
          state_d       = fern_pkg::ST_XA;
        end
      end
      fern_pkg::ST_XA: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = fern_pkg::MUL_XA;
        state_d       = fern_pkg::ST_XB;
      end
      fern_pkg::ST_XB: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = fern_pkg::MUL_XB;
        cmd_o.acc_load = 1'b1;
        state_d        = fern_pkg::ST_YA;
      end
      fern_pkg::ST_YA: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = fern_pkg::MUL_YA;
        cmd_o.x_done  = 1'b1;
        state_d       = fern_pkg::ST_YB;
      end
      fern_pkg::ST_YB: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = fern_pkg::MUL_YB;
        cmd_o.acc_load = 1'b1;
        state_d        = fern_pkg::ST_PX;
      end
      fern_pkg::ST_PX: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = fern_pkg::MUL_COL;
        cmd_o.y_done  = 1'b1;
        state_d       = fern_pkg::ST_PY;
      end
      fern_pkg::ST_PY: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = fern_pkg::MUL_ROW;
        cmd_o.col_load = 1'b1;
        state_d        = fern_pkg::ST_DONE;
      end
      fern_pkg::ST_DONE: begin
        // hold the row product until the result register frees up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = fern_pkg::ST_IDLE;
        end
      end
      default: state_d = fern_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[sv/fern_dp.sv]
// Datapath: point state, view registers, shared multiplier, result register.
module fern_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fern_pkg::cmd_t                      cmd_i,
  input  logic [fern_pkg::RAND_W-1:0]         random_fraction_i,
  input  logic                                cfg_we_i,
  input  logic [fern_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [fern_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output logic [fern_pkg::PIX_W-1:0]          pixel_col_o,
  output logic [fern_pkg::PIX_W-1:0]          pixel_row_o,
  output logic                                in_view_o,
  output logic signed [fern_pkg::PT_W-1:0]    new_point_x_o,
  output logic signed [fern_pkg::PT_W-1:0]    new_point_y_o,
  output logic [1:0]                          map_used_o
);

  localparam int PT_W   = fern_pkg::PT_W;
  localparam int PROD_W = fern_pkg::PROD_W;
  localparam int SUM_W  = fern_pkg::SUM_W;
  localparam int PIXQ_W = fern_pkg::PIXQ_W;
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(fern_pkg::Q_MAX);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(fern_pkg::Q_MIN);

  logic signed [PT_W-1:0]    pt_x_q, pt_y_q;
  logic signed [PT_W-1:0]    view_left_q, view_top_q;
  logic [fern_pkg::SCALE_W-1:0] xppu_q, yppu_q;
  fern_pkg::map_e            map_q, map_d;

  logic signed [PROD_W-1:0]  prod_q, prod_d, acc_q;
  logic signed [PT_W-1:0]    nx_q, ny_q, sat_x, sat_y;
  logic signed [PIXQ_W-1:0]  col_q, row_w;

  logic signed [fern_pkg::MUL_A_W-1:0] mul_a;
  logic signed [fern_pkg::MUL_B_W-1:0] mul_b;
  fern_pkg::coef_t           coef;
  logic                      vis;

  logic [fern_pkg::PIX_W-1:0] out_col_q, out_row_q;
  logic                       out_vis_q;
  logic signed [PT_W-1:0]     out_x_q, out_y_q;
  logic [1:0]                 out_map_q;

  // floor(sum / 2^16) + offset, clamped to the Q5.16 range
  function automatic logic signed [PT_W-1:0] sat_step(
    input logic signed [PROD_W-1:0] s,
    input logic signed [17:0]       off
  );
    logic signed [SUM_W-1:0] v;
    logic signed [PT_W-1:0]  r;
    v = SUM_W'($signed(s[PROD_W-1:fern_pkg::FRAC_W])) + SUM_W'(off);
    if (v > SAT_HI) begin
      r = PT_W'(SAT_HI);
    end else if (v < SAT_LO) begin
      r = PT_W'(SAT_LO);
    end else begin
      r = v[PT_W-1:0];
    end
    return r;
  endfunction

  always_comb begin
    if (random_fraction_i < fern_pkg::THR_FROND) begin
      map_d = fern_pkg::MAP_STEM;
    end else if (random_fraction_i < fern_pkg::THR_LEFT) begin
      map_d = fern_pkg::MAP_FROND;
    end else if (random_fraction_i < fern_pkg::THR_RIGHT) begin
      map_d = fern_pkg::MAP_LEFT;
    end else begin
      map_d = fern_pkg::MAP_RIGHT;
    end
  end

  assign coef = fern_pkg::fern_coef(map_q);

  always_comb begin
    mul_a = fern_pkg::MUL_A_W'(pt_x_q);
    mul_b = fern_pkg::MUL_B_W'(coef.ax);
    case (cmd_i.mul_sel)
      fern_pkg::MUL_XA: begin
        mul_a = fern_pkg::MUL_A_W'(pt_x_q);
        mul_b = fern_pkg::MUL_B_W'(coef.ax);
      end
      fern_pkg::MUL_XB: begin
        mul_a = fern_pkg::MUL_A_W'(pt_y_q);
        mul_b = fern_pkg::MUL_B_W'(coef.bx);
      end
      fern_pkg::MUL_YA: begin
        mul_a = fern_pkg::MUL_A_W'(pt_x_q);
        mul_b = fern_pkg::MUL_B_W'(coef.ay);
      end
      fern_pkg::MUL_YB: begin
        mul_a = fern_pkg::MUL_A_W'(pt_y_q);
        mul_b = fern_pkg::MUL_B_W'(coef.by);
      end
      fern_pkg::MUL_COL: begin
        mul_a = fern_pkg::MUL_A_W'(nx_q) - fern_pkg::MUL_A_W'(view_left_q);
        mul_b = $signed({1'b0, xppu_q});
      end
      fern_pkg::MUL_ROW: begin
        mul_a = fern_pkg::MUL_A_W'(view_top_q) - fern_pkg::MUL_A_W'(ny_q);
        mul_b = $signed({1'b0, yppu_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;
  assign sat_x  = sat_step(acc_q + prod_q, coef.offx);
  assign sat_y  = sat_step(acc_q + prod_q, coef.offy);
  assign row_w  = prod_q[PROD_W-1:32];

  assign vis = !col_q[PIXQ_W-1] && (col_q[PIXQ_W-2:0] < (PIXQ_W-1)'(fern_pkg::IMG_W)) &&
               !row_w[PIXQ_W-1] && (row_w[PIXQ_W-2:0] < (PIXQ_W-1)'(fern_pkg::IMG_H));

  // point state and view registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_x_q      <= '0;
      pt_y_q      <= '0;
      view_left_q <= fern_pkg::VIEW_LEFT_RST;
      view_top_q  <= fern_pkg::VIEW_TOP_RST;
      xppu_q      <= fern_pkg::XPPU_RST;
      yppu_q      <= fern_pkg::YPPU_RST;
    end else begin
      if (cmd_i.out_load) begin
        pt_x_q <= nx_q;
        pt_y_q <= ny_q;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          fern_pkg::REG_VIEW_LEFT: view_left_q <= cfg_data_i[PT_W-1:0];
          fern_pkg::REG_VIEW_TOP:  view_top_q  <= cfg_data_i[PT_W-1:0];
          fern_pkg::REG_XPPU:      xppu_q      <= cfg_data_i;
          fern_pkg::REG_YPPU:      yppu_q      <= cfg_data_i;
          default: ;  // unmapped index, write dropped
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in)  map_q  <= map_d;
    if (cmd_i.mul_en)   prod_q <= prod_d;
    if (cmd_i.acc_load) acc_q  <= prod_q;
    if (cmd_i.x_done)   nx_q   <= sat_x;
    if (cmd_i.y_done)   ny_q   <= sat_y;
    if (cmd_i.col_load) col_q  <= prod_q[PROD_W-1:32];
    if (cmd_i.out_load) begin
      out_col_q <= vis ? col_q[fern_pkg::PIX_W-1:0] : '0;
      out_row_q <= vis ? row_w[fern_pkg::PIX_W-1:0] : '0;
      out_vis_q <= vis;
      out_x_q   <= nx_q;
      out_y_q   <= ny_q;
      out_map_q <= map_q;
    end
  end

  assign pixel_col_o   = out_col_q;
  assign pixel_row_o   = out_row_q;
  assign in_view_o     = out_vis_q;
  assign new_point_x_o = out_x_q;
  assign new_point_y_o = out_y_q;
  assign map_used_o    = out_map_q;

endmodule

[sv/fern_ifs_point_plotter.sv]
// Top level of the fern point plotter: sequencer plus datapath.
//
//   channel   dir   word
//   in_i      in    random_fraction[15:0]
//   out_o     out   pixel_col, pixel_row, in_view, new_point_x, new_point_y, map_used
//   cfg_i     in    index[3:0], data[31:0] (0 view_left, 1 view_top, 2/3 x/y scale)
//
// Each word is handled alone, from accept to the next accept: six passes through
// the single 23x33 multiplier (two affine products per coordinate, then column
// and row), then the result register is loaded and the sequencer returns to idle.
// Reset puts the point at the origin and loads the default view; no clear pass.
// A stalled result holds in its register; a finished word waits in the last
// step until that register frees up. Config writes are always taken.
module fern_ifs_point_plotter (
  input  logic       clk_i,
  input  logic       rst_ni,
  fern_in_if.sink    in_i,
  fern_out_if.source out_o,
  fern_cfg_if.sink   cfg_i
);

  fern_pkg::cmd_t cmd;

  assign cfg_i.ready = 1'b1;

  fern_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (cmd)
  );

  fern_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .random_fraction_i (in_i.random_fraction),
    .cfg_we_i          (cfg_i.valid),
    .cfg_index_i       (cfg_i.index),
    .cfg_data_i        (cfg_i.data),
    .pixel_col_o       (out_o.pixel_col),
    .pixel_row_o       (out_o.pixel_row),
    .in_view_o         (out_o.in_view),
    .new_point_x_o     (out_o.new_point_x),
    .new_point_y_o     (out_o.new_point_y),
    .map_used_o        (out_o.map_used)
  );

endmodule

[sv/fern_chk.sv]
// Port-level checker for the fern point plotter, bound to the top level.
module fern_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic [fern_pkg::PIX_W-1:0]       pixel_col_i,
  input logic [fern_pkg::PIX_W-1:0]       pixel_row_i,
  input logic                             in_view_i,
  input logic signed [fern_pkg::PT_W-1:0] new_point_x_i,
  input logic signed [fern_pkg::PT_W-1:0] new_point_y_i,
  input logic [1:0]                       map_used_i
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({pixel_col_i, pixel_row_i, in_view_i, new_point_x_i, new_point_y_i, map_used_i}))
    else $error("result word changed while stalled");

  // one word in flight: accept closes the input until the word is done
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted while a word is in flight");

  a_off_view_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !in_view_i |-> pixel_col_i == '0 && pixel_row_i == '0)
    else $error("pixel nonzero for a point out of view");

  a_stem_x_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && map_used_i == fern_pkg::MAP_STEM |-> new_point_x_i == '0)
    else $error("stem map gave nonzero x");

endmodule

bind fern_ifs_point_plotter fern_chk u_fern_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .pixel_col_i   (out_o.pixel_col),
  .pixel_row_i   (out_o.pixel_row),
  .in_view_i     (out_o.in_view),
  .new_point_x_i (out_o.new_point_x),
  .new_point_y_i (out_o.new_point_y),
  .map_used_i    (out_o.map_used)
);

[sim/tb_fern_ifs_point_plotter.sv]
// Self-checking testbench for the fern point plotter: random words, view sweeps, handshake stress.
`timescale 1ns / 100ps

module tb_fern_ifs_point_plotter;
  import fern_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_WORDS  = 75;
  localparam int PHASE_COUNT  = 8;
  localparam int DRAIN_CYCLES = 12;
  localparam int SHOW_LIMIT   = 40;
  localparam int UNIT         = 65536;

  // thresholds and their neighbors, both ends of the field, then words that
  // walk the point through every map from away from the origin
  localparam logic [RAND_W-1:0] EDGE_WORDS [17] = '{
    16'd0, 16'd655, 16'd656, 16'd56360, 16'd56361, 16'd60948, 16'd60949, 16'd65535,
    16'd1000, 16'd30000, 16'd57000, 16'd62000, 16'd100, 16'd20000, 16'd58000,
    16'd64000, 16'd45000
  };

  typedef struct {
    logic [PIX_W-1:0]       col;
    logic [PIX_W-1:0]       row;
    logic                   vis;
    logic signed [PT_W-1:0] px;
    logic signed [PT_W-1:0] py;
    map_e                   map;
  } plot_t;

  logic clk_i;
  logic rst_ni;

  fern_in_if  word_ch ();
  fern_out_if plot_ch ();
  fern_cfg_if cfg_ch ();

  fern_ifs_point_plotter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (word_ch),
    .out_o  (plot_ch),
    .cfg_i  (cfg_ch)
  );

  // model copy of the view registers and the point
  logic signed [PT_W-1:0] view_left_q = VIEW_LEFT_RST;
  logic signed [PT_W-1:0] view_top_q  = VIEW_TOP_RST;
  logic [SCALE_W-1:0]     x_scale_q   = XPPU_RST;
  logic [SCALE_W-1:0]     y_scale_q   = YPPU_RST;
  logic signed [PT_W-1:0] cur_x = '0;
  logic signed [PT_W-1:0] cur_y = '0;

  logic [RAND_W-1:0] fraction_q[$];
  plot_t             plot_q[$];
  plot_t             want;

  logic in_taken = 1'b0;
  int   send_gap_pct = 0;
  int   stall_pct = 0;
  int   mismatches = 0;
  int   cycles = 0;
  int   words_taken = 0;
  int   plots_checked = 0;
  int   plots_in_view = 0;
  int   map_hits [4] = '{0, 0, 0, 0};

  function automatic longint clamp_q(input longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  // one fern iteration on the model point, then the pixel projection
  function automatic plot_t fern_step(input logic [RAND_W-1:0] r);
    longint ax, bx, ox, ay, by, oy;
    longint x, y, nx, ny, col, row;
    plot_t p;
    x = cur_x;
    y = cur_y;
    if (r < THR_FROND) begin
      p.map = MAP_STEM;
      ax = 0;     bx = 0;      ox = 0; ay = 0;     by = 10486; oy = 0;
    end else if (r < THR_LEFT) begin
      p.map = MAP_FROND;
      ax = 55706; bx = 2621;   ox = 0; ay = -2621; by = 55706; oy = 104858;
    end else if (r < THR_RIGHT) begin
      p.map = MAP_LEFT;
      ax = 13107; bx = -17039; ox = 0; ay = 15073; by = 14418; oy = 104858;
    end else begin
      p.map = MAP_RIGHT;
      ax = -9830; bx = 18350;  ox = 0; ay = 17039; by = 15729; oy = 28836;
    end
    // >>> on a signed longint floors toward minus infinity
    nx = clamp_q(((ax * x + bx * y) >>> FRAC_W) + ox);
    ny = clamp_q(((ay * x + by * y) >>> FRAC_W) + oy);
    cur_x = nx[PT_W-1:0];
    cur_y = ny[PT_W-1:0];
    col = ((nx - longint'(view_left_q)) * longint'({32'd0, x_scale_q})) >>> 32;
    row = ((longint'(view_top_q) - ny) * longint'({32'd0, y_scale_q})) >>> 32;
    p.vis = (col >= 0) && (col < IMG_W) && (row >= 0) && (row < IMG_H);
    p.col = p.vis ? col[PIX_W-1:0] : '0;
    p.row = p.vis ? row[PIX_W-1:0] : '0;
    p.px  = nx[PT_W-1:0];
    p.py  = ny[PT_W-1:0];
    return p;
  endfunction

  task automatic report(input string field, input longint got, input longint exp_v);
    if (mismatches < SHOW_LIMIT)
      $display("mismatch at cycle %0d on result %0d: %s got %0d want %0d",
               cycles, plots_checked, field, got, exp_v);
    mismatches++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // loads the whole view; unused upper data bits and a stray index get junk
  task automatic set_view(input logic signed [PT_W-1:0] left, input logic signed [PT_W-1:0] top,
                          input logic [SCALE_W-1:0] xs, input logic [SCALE_W-1:0] ys);
    logic [31:0] pad;
    pad = $urandom();
    write_reg(REG_VIEW_LEFT, {pad[31:22], left});
    pad = $urandom();
    write_reg(REG_VIEW_TOP, {pad[31:22], top});
    write_reg(REG_XPPU, xs);
    write_reg(REG_YPPU, ys);
    write_reg(CFG_IDX_W'($urandom_range(4, 15)), $urandom());
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (fraction_q.size() != 0 || word_ch.valid || plot_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [RAND_W-1:0] pick_word();
    int k;
    k = $urandom_range(9);
    if (k == 0) begin
      case ($urandom_range(2))
        0: return THR_FROND + RAND_W'($urandom_range(6)) - 16'd3;
        1: return THR_LEFT + RAND_W'($urandom_range(6)) - 16'd3;
        default: return THR_RIGHT + RAND_W'($urandom_range(6)) - 16'd3;
      endcase
    end
    if (k == 1) return ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
    return RAND_W'($urandom_range(65535));
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycles, plot_q.size());
      $display("tb_fern_ifs_point_plotter: FAIL");
      $finish;
    end
  end

  // word driver and result back-pressure
  always @(negedge clk_i) begin
    if (rst_ni && (!word_ch.valid || in_taken)) begin
      if (fraction_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        word_ch.valid           <= 1'b1;
        word_ch.random_fraction <= fraction_q.pop_front();
      end else begin
        word_ch.valid           <= 1'b0;
        word_ch.random_fraction <= RAND_W'($urandom());
      end
    end
    plot_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // check results first, then track config and accepted words
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (plot_ch.valid && plot_ch.ready) begin
        if (plot_q.size() == 0) begin
          report("unexpected result", plot_ch.new_point_x, 0);
        end else begin
          want = plot_q.pop_front();
          if (plot_ch.pixel_col !== want.col) report("pixel_col", plot_ch.pixel_col, want.col);
          if (plot_ch.pixel_row !== want.row) report("pixel_row", plot_ch.pixel_row, want.row);
          if (plot_ch.in_view !== want.vis) report("in_view", plot_ch.in_view, want.vis);
          if (plot_ch.new_point_x !== want.px)
            report("new_point_x", plot_ch.new_point_x, want.px);
          if (plot_ch.new_point_y !== want.py)
            report("new_point_y", plot_ch.new_point_y, want.py);
          if (plot_ch.map_used !== want.map) report("map_used", plot_ch.map_used, want.map);
          plots_checked++;
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_VIEW_LEFT: view_left_q = cfg_ch.data[PT_W-1:0];
          REG_VIEW_TOP:  view_top_q  = cfg_ch.data[PT_W-1:0];
          REG_XPPU:      x_scale_q   = cfg_ch.data;
          REG_YPPU:      y_scale_q   = cfg_ch.data;
          default: ;
        endcase
      end
      in_taken = word_ch.valid && word_ch.ready;
      if (in_taken) begin
        want = fern_step(word_ch.random_fraction);
        plot_q.push_back(want);
        words_taken++;
        map_hits[want.map]++;
        if (want.vis) plots_in_view++;
      end
    end
  end

  initial begin
    rst_ni                  = 1'b0;
    word_ch.valid           = 1'b0;
    word_ch.random_fraction = '0;
    plot_ch.ready           = 1'b0;
    cfg_ch.valid            = 1'b0;
    cfg_ch.index            = '0;
    cfg_ch.data             = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset view, directed words, no idling
    foreach (EDGE_WORDS[i]) fraction_q.push_back(EDGE_WORDS[i]);
    drain();

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0: set_view(VIEW_LEFT_RST, VIEW_TOP_RST, XPPU_RST, YPPU_RST);
        // extreme view: everything lands far off the image
        1: set_view(PT_W'(Q_MIN), PT_W'(Q_MAX), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // zero scale on x only
        2: set_view(PT_W'(Q_MAX), VIEW_TOP_RST, 32'd0, YPPU_RST);
        // zero scale on y only
        3: set_view(VIEW_LEFT_RST, PT_W'(Q_MIN), XPPU_RST, 32'd0);
        // zoomed in so the right side spills past the image
        4: set_view(-PT_W'(163840), PT_W'(655360), 32'd16384000, 32'd6553600);
        5: set_view(PT_W'($urandom()), PT_W'($urandom()), $urandom(), $urandom());
        6: set_view(-PT_W'($urandom_range(4 * UNIT)), PT_W'($urandom_range(9 * UNIT, 12 * UNIT)),
                    $urandom_range(400 * UNIT), $urandom_range(200 * UNIT));
        default: set_view(VIEW_LEFT_RST, VIEW_TOP_RST, XPPU_RST, YPPU_RST);
      endcase
      case (ph % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 59; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 59; end
        default: begin send_gap_pct = 14; stall_pct = 14; end
      endcase
      for (int n = 0; n < PHASE_WORDS; n++) fraction_q.push_back(pick_word());
      drain();
    end

    $display("covered %0d words over %0d view settings, %0d results checked, %0d in view",
             words_taken, PHASE_COUNT + 1, plots_checked, plots_in_view);
    $display("maps taken: stem %0d, frond %0d, left leaf %0d, right leaf %0d",
             map_hits[0], map_hits[1], map_hits[2], map_hits[3]);
    if (mismatches == 0) begin
      $display("tb_fern_ifs_point_plotter: PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb_fern_ifs_point_plotter: FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/fern_pkg.sv
sv/fern_if.sv
sv/fern_ctrl.sv
sv/fern_dp.sv
sv/fern_ifs_point_plotter.sv
sv/fern_chk.sv
sim/tb_fern_ifs_point_plotter.sv
